@@ src/iirdf1_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IIR direct-form-I filter package
// Shared constants, register indexes and the control word of the MAC unit.
// ---------------------------------------------------------------------------
package iirdf1_pkg;

	localparam int MAX_ORDER_DEF = 7;
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 16;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	localparam int ACC_W_DEF     = PROD_W + $clog2(MAX_ORDER_DEF + 1);
	localparam int CFG_W         = 64;
	localparam int SHIFT_W       = 5;
	localparam int ORDER_W       = 3;

	localparam logic [ORDER_W-1:0] ORDER_RESET   = ORDER_W'(7);
	localparam logic [SHIFT_W-1:0] SHIFT_A_RESET = SHIFT_W'(15 + 8);
	localparam logic [SHIFT_W-1:0] SHIFT_B_RESET = SHIFT_W'(15 - 4);

	typedef enum logic [2:0] {
		REG_FILTER_ORDER    = 3'd0,
		REG_FIR_ONLY        = 3'd1,
		REG_FEED_COEFS_LOW  = 3'd2,
		REG_FEED_COEFS_HIGH = 3'd3,
		REG_BACK_COEFS_LOW  = 3'd4,
		REG_BACK_COEFS_HIGH = 3'd5,
		REG_SHIFT_A         = 3'd6,
		REG_SHIFT_B         = 3'd7
	} reg_idx_t;

	// Control word from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;     // zero both accumulators
		logic issue;     // start one product this cycle
		logic feedback;  // product belongs to the feedback sum
	} mac_ctrl_t;

endpackage

@@ src/iirdf1_mac.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IIR filter multiply-accumulate unit
// One registered 16x16 signed multiplier feeding two accumulators, one for
// the feedforward sum and one for the feedback sum.
// ---------------------------------------------------------------------------
module iirdf1_mac #(
	parameter int ACC_W = iirdf1_pkg::ACC_W_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  iirdf1_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [iirdf1_pkg::COEF_W-1:0]  coef,
	input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample,
	output logic signed [ACC_W-1:0]               acc_a,
	output logic signed [ACC_W-1:0]               acc_b
);

	logic signed [iirdf1_pkg::PROD_W-1:0] prod_s1;
	logic                                 vld_s1;
	logic                                 fb_s1;
	logic signed [ACC_W-1:0]              acc_a_q;
	logic signed [ACC_W-1:0]              acc_b_q;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			fb_s1   <= 1'b0;
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else begin
			vld_s1 <= ctrl.issue;
			fb_s1  <= ctrl.feedback;
			if (ctrl.clear) begin
				acc_a_q <= '0;
				acc_b_q <= '0;
			end else if (vld_s1) begin
				if (fb_s1) begin
					acc_b_q <= acc_b_q + ACC_W'(prod_s1);
				end else begin
					acc_a_q <= acc_a_q + ACC_W'(prod_s1);
				end
			end
		end
	end

	assign acc_a = acc_a_q;
	assign acc_b = acc_b_q;

endmodule

@@ src/iir_filter_direct_form1.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IIR filter, direct form I
// Configurable order up to MAX_ORDER, 16-bit fixed point, saturating output.
// ---------------------------------------------------------------------------
//  channel   signals                                  direction
//  config    cfg_we, cfg_index, cfg_data              in, write only
//  input     in_valid, in_ready, sample_in            in
//  output    out_valid, out_ready, sample_out, sat.   out
//
// Each sample runs through the feedforward taps, then the feedback taps,
// which FIR mode skips. The shared multiplier issues one tap per cycle,
// followed by a drain step and a combine step.
// Reset clears the histories, heads and registers to their defaults.
// The finished sample sits in an output register; a new input is accepted
// while it waits, and only the combine step holds for a stalled output.
// ---------------------------------------------------------------------------
module iir_filter_direct_form1 #(
	parameter int MAX_ORDER = iirdf1_pkg::MAX_ORDER_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [2:0]                              cfg_index,
	input  logic [iirdf1_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [iirdf1_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                    saturated
);

	localparam int HW    = $clog2(MAX_ORDER + 1);
	localparam int OHW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int ACC_W = iirdf1_pkg::PROD_W + $clog2(MAX_ORDER + 1);
	localparam int YW    = ACC_W + 1;
	localparam int SW    = iirdf1_pkg::SAMPLE_W;

	localparam logic signed [YW-1:0] Y_MAX = YW'(32767);
	localparam logic signed [YW-1:0] Y_MIN = -YW'(32768);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FF,
		S_FB,
		S_DRAIN,
		S_COMB
	} state_t;

	function automatic logic signed [15:0] coef_a(input logic [63:0] lo,
		input logic [63:0] hi, input int unsigned i);
		logic signed [15:0] c;
		c = '0;
		if (i < 4) begin
			c = lo[16*(i % 4) +: 16];
		end else if (i < 8) begin
			c = hi[16*(i % 4) +: 16];
		end
		return c;
	endfunction

	// Index 0 selects b1.
	function automatic logic signed [15:0] coef_b(input logic [63:0] lo,
		input logic [47:0] hi, input int unsigned i);
		logic signed [15:0] c;
		c = '0;
		if (i < 4) begin
			c = lo[16*(i % 4) +: 16];
		end else if (i < 7) begin
			c = hi[16*(i % 4) +: 16];
		end
		return c;
	endfunction

	// Configuration registers
	logic [iirdf1_pkg::ORDER_W-1:0] order_q;
	logic                           fir_q;
	logic [63:0]                    fa_lo_q;
	logic [63:0]                    fa_hi_q;
	logic [63:0]                    fb_lo_q;
	logic [47:0]                    fb_hi_q;
	logic [iirdf1_pkg::SHIFT_W-1:0] sa_q;
	logic [iirdf1_pkg::SHIFT_W-1:0] sb_q;

	// Histories and sequencer state
	logic signed [SW-1:0] in_hist_q  [0:MAX_ORDER];
	logic signed [SW-1:0] out_hist_q [0:MAX_ORDER-1];
	logic [HW-1:0]        ih_q;
	logic [OHW-1:0]       oh_q;
	logic [HW-1:0]        idx_q;
	logic [OHW-1:0]       oidx_q;
	logic [HW-1:0]        cnt_q;
	state_t               state_q;
	logic                 out_valid_q;
	logic signed [SW-1:0] sample_out_q;
	logic                 sat_q;

	logic [HW-1:0]         ord_eff;
	logic [HW-1:0]         ord_m1;
	logic [HW-1:0]         ih_next;
	logic [OHW-1:0]        oh_next;
	logic [OHW-1:0]        oidx_start;
	logic                  in_xfer;
	logic                  out_free;
	iirdf1_pkg::mac_ctrl_t mac_ctrl;
	logic signed [15:0]    mac_coef;
	logic signed [SW-1:0]  mac_sample;
	logic signed [ACC_W-1:0] acc_a;
	logic signed [ACC_W-1:0] acc_b;
	logic signed [YW-1:0]  y_full;
	logic signed [SW-1:0]  y_sat;
	logic                  y_clip;

	// Order clamped to 1..MAX_ORDER.
	always_comb begin
		if (order_q == '0) begin
			ord_eff = HW'(1);
		end else if (int'(order_q) > MAX_ORDER) begin
			ord_eff = HW'(MAX_ORDER);
		end else begin
			ord_eff = HW'(order_q);
		end
	end

	assign ord_m1 = ord_eff - HW'(1);

	always_comb begin
		if (ih_q == '0 || ih_q > ord_eff) begin
			ih_next = ord_eff;
		end else begin
			ih_next = ih_q - HW'(1);
		end
		if (oh_q == '0 || HW'(oh_q) > ord_m1) begin
			oh_next = OHW'(ord_m1);
		end else begin
			oh_next = oh_q - OHW'(1);
		end
		// The output head can be stale after the order was lowered.
		if (HW'(oh_q) >= ord_eff) begin
			oidx_start = '0;
		end else begin
			oidx_start = oh_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		mac_ctrl          = '0;
		mac_ctrl.clear    = in_xfer;
		mac_coef          = '0;
		mac_sample        = '0;
		if (state_q == S_FF) begin
			mac_ctrl.issue = 1'b1;
			mac_coef       = coef_a(fa_lo_q, fa_hi_q, int'(cnt_q));
			mac_sample     = in_hist_q[idx_q];
		end else if (state_q == S_FB) begin
			mac_ctrl.issue    = 1'b1;
			mac_ctrl.feedback = 1'b1;
			mac_coef          = coef_b(fb_lo_q, fb_hi_q, int'(cnt_q));
			mac_sample        = out_hist_q[oidx_q];
		end
	end

	iirdf1_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (mac_coef),
		.sample (mac_sample),
		.acc_a  (acc_a),
		.acc_b  (acc_b)
	);

	// Arithmetic shifts round toward minus infinity, as required.
	always_comb begin
		y_full = YW'(acc_a >>> sa_q) - YW'(acc_b >>> sb_q);
		y_clip = 1'b1;
		if (y_full > Y_MAX) begin
			y_sat = SW'(32767);
		end else if (y_full < Y_MIN) begin
			y_sat = SW'(-32768);
		end else begin
			y_sat  = SW'(y_full);
			y_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= iirdf1_pkg::ORDER_RESET;
			fir_q   <= 1'b0;
			fa_lo_q <= '0;
			fa_hi_q <= '0;
			fb_lo_q <= '0;
			fb_hi_q <= '0;
			sa_q    <= iirdf1_pkg::SHIFT_A_RESET;
			sb_q    <= iirdf1_pkg::SHIFT_B_RESET;
		end else if (cfg_we) begin
			unique case (iirdf1_pkg::reg_idx_t'(cfg_index))
				iirdf1_pkg::REG_FILTER_ORDER:    order_q <= cfg_data[iirdf1_pkg::ORDER_W-1:0];
				iirdf1_pkg::REG_FIR_ONLY:        fir_q   <= cfg_data[0];
				iirdf1_pkg::REG_FEED_COEFS_LOW:  fa_lo_q <= cfg_data;
				iirdf1_pkg::REG_FEED_COEFS_HIGH: fa_hi_q <= cfg_data;
				iirdf1_pkg::REG_BACK_COEFS_LOW:  fb_lo_q <= cfg_data;
				iirdf1_pkg::REG_BACK_COEFS_HIGH: fb_hi_q <= cfg_data[47:0];
				iirdf1_pkg::REG_SHIFT_A:         sa_q    <= cfg_data[iirdf1_pkg::SHIFT_W-1:0];
				iirdf1_pkg::REG_SHIFT_B:         sb_q    <= cfg_data[iirdf1_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ih_q         <= '0;
			oh_q         <= '0;
			idx_q        <= '0;
			oidx_q       <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			sat_q        <= 1'b0;
			for (int i = 0; i <= MAX_ORDER; i++) begin
				in_hist_q[i] <= '0;
			end
			for (int i = 0; i < MAX_ORDER; i++) begin
				out_hist_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						ih_q               <= ih_next;
						in_hist_q[ih_next] <= sample_in;
						idx_q              <= ih_next;
						cnt_q              <= '0;
						state_q            <= S_FF;
					end
				end
				S_FF: begin
					cnt_q <= cnt_q + HW'(1);
					idx_q <= (idx_q == ord_eff) ? '0 : idx_q + HW'(1);
					if (cnt_q == ord_eff) begin
						cnt_q  <= '0;
						oidx_q <= oidx_start;
						state_q <= fir_q ? S_DRAIN : S_FB;
					end
				end
				S_FB: begin
					cnt_q  <= cnt_q + HW'(1);
					oidx_q <= (HW'(oidx_q) + HW'(1) >= ord_eff) ? '0 : oidx_q + OHW'(1);
					if (cnt_q == ord_m1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMB;
				end
				S_COMB: begin
					if (out_free) begin
						sample_out_q        <= y_sat;
						sat_q               <= y_clip;
						out_valid_q         <= 1'b1;
						oh_q                <= oh_next;
						out_hist_q[oh_next] <= y_sat;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = sat_q;

endmodule
